// File: hw/rtl/bchd_pkg.sv
// Shared types, register codes and constants of the button click and hold detector.
`timescale 1ns / 1ps
`default_nettype none
package bchd_pkg;

	localparam int AGE_W   = 16;
	localparam int CLICK_W = 8;
	localparam int ADC_W   = 10;
	localparam int IDX_W   = 3;

	localparam logic [ADC_W-1:0]   ANALOG_THRESHOLD = 10'd512;
	localparam logic [AGE_W-1:0]   AGE_MAX          = 16'hFFFF;
	localparam logic [CLICK_W-1:0] CLICKS_MAX       = 8'hFF;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_USE_DIGITAL   = 3'd0;
	localparam logic [IDX_W-1:0] REG_INVERT_LEVEL  = 3'd1;
	localparam logic [IDX_W-1:0] REG_DEBOUNCE      = 3'd2;
	localparam logic [IDX_W-1:0] REG_CLICK_TIMEOUT = 3'd3;
	localparam logic [IDX_W-1:0] REG_HOLD          = 3'd4;
	localparam logic [IDX_W-1:0] REG_MAX_CLICKS    = 3'd5;

	typedef struct packed {
		logic             digital_level;
		logic [ADC_W-1:0] analog_sample;
	} item_t;

	typedef struct packed {
		logic               pressed;
		logic               held;
		logic               click_report;
		logic [CLICK_W-1:0] click_total;
		logic               hold_began;
		logic               hold_ended;
	} result_t;

	typedef struct packed {
		logic               use_digital;
		logic               invert_level;
		logic [AGE_W-1:0]   debounce_ticks;
		logic [AGE_W-1:0]   click_timeout_ticks;
		logic [AGE_W-1:0]   hold_ticks;
		logic [CLICK_W-1:0] max_clicks;
	} cfg_t;

	// Classified tick handed from the front end to the back end.
	typedef struct packed {
		logic valid;
		logic raw;
	} tick_t;

endpackage
`default_nettype wire

// File: hw/rtl/bchd_front.sv
// Front end: takes input beats, derives the raw button level and queues it.
`timescale 1ns / 1ps
`default_nettype none
module bchd_front import bchd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  push,
	output logic       full,
	input  wire item_t item,
	output tick_t      tick,
	input  wire logic  take
);

	logic       slot_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] count_q;
	logic       raw;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		raw = cfg.use_digital ? item.digital_level : (item.analog_sample > ANALOG_THRESHOLD);
		raw = raw ^ cfg.invert_level;
	end

	assign full       = count_q[1];
	assign do_push    = push && !full;
	assign tick.valid = count_q != 2'd0;
	assign tick.raw   = slot_q[rd_ptr_q];
	assign do_pop     = take && tick.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/bchd_back.sv
// Back end: debounce, click and hold tracking, and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module bchd_back import bchd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire tick_t tick,
	output logic       take,
	output logic       empty,
	input  wire logic  pop,
	output result_t    result
);

	logic               prev_raw_q;
	logic               debounced_q;
	logic               holding_q;
	logic [AGE_W-1:0]   stable_age_q;
	logic [AGE_W-1:0]   press_age_q;
	logic [AGE_W-1:0]   release_age_q;
	logic [CLICK_W-1:0] pending_q;

	logic [AGE_W-1:0]   stable_age;
	logic [AGE_W-1:0]   press_age;
	logic [AGE_W-1:0]   release_age;
	logic [CLICK_W-1:0] pending;
	logic               deb;
	logic               hold;
	result_t            res;

	result_t    slot_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign take   = tick.valid && !count_q[1];
	assign empty  = count_q == 2'd0;
	assign result = slot_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_comb begin
		stable_age  = (stable_age_q  == AGE_MAX) ? AGE_MAX : stable_age_q  + 16'd1;
		press_age   = (press_age_q   == AGE_MAX) ? AGE_MAX : press_age_q   + 16'd1;
		release_age = (release_age_q == AGE_MAX) ? AGE_MAX : release_age_q + 16'd1;
		pending     = pending_q;
		hold        = holding_q;
		res         = '0;

		if (tick.raw != prev_raw_q) begin
			stable_age = '0;
		end
		deb = (stable_age > cfg.debounce_ticks) ? tick.raw : debounced_q;

		// debounced_q also serves as the previous debounced state.
		if (deb) begin
			if (!debounced_q) begin
				press_age = '0;
			end else if (!holding_q && press_age >= cfg.hold_ticks) begin
				if (pending != '0) begin
					res.click_report = 1'b1;
					res.click_total  = pending;
					pending          = '0;
				end
				hold           = 1'b1;
				res.hold_began = 1'b1;
			end
		end else begin
			if (holding_q) begin
				hold           = 1'b0;
				res.hold_ended = 1'b1;
			end else if (debounced_q) begin
				if (pending != CLICKS_MAX) begin
					pending = pending + 8'd1;
				end
				release_age = '0;
				if (pending >= cfg.max_clicks) begin
					res.click_report = 1'b1;
					res.click_total  = pending;
					pending          = '0;
				end
			end
		end

		if (release_age >= cfg.click_timeout_ticks && pending != '0) begin
			res.click_report = 1'b1;
			res.click_total  = pending;
			pending          = '0;
		end

		res.pressed = deb;
		res.held    = hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q    <= 1'b0;
			debounced_q   <= 1'b0;
			holding_q     <= 1'b0;
			stable_age_q  <= '0;
			press_age_q   <= '0;
			release_age_q <= '0;
			pending_q     <= '0;
		end else if (take) begin
			prev_raw_q    <= tick.raw;
			debounced_q   <= deb;
			holding_q     <= hold;
			stable_age_q  <= stable_age;
			press_age_q   <= press_age;
			release_age_q <= release_age;
			pending_q     <= pending;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			slot_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (take) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (take && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !take) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/button_click_hold_detector.sv
// Top level of the button click and hold detector: configuration registers and the two halves.
// Usage:
// Each input beat is one millisecond tick with a digital level and a 10-bit analog sample.
// A beat is taken at a rising edge with push high and full low. Every input beat gives
// exactly one result beat, in order: the debounced pressed and held state, a click count
// report, and hold start and hold end flags. A result waits on the result ports while
// empty is low and is taken at a rising edge with pop high.
// A beat taken into the input queue goes through the back end into the result queue, and then
// shows on the result ports and can be popped. Throughput is one beat per cycle while the
// receiver keeps popping; the back end updates its state as it takes each beat, and a
// two-entry queue on each side of it keeps that rate while results wait.
// When the receiver stalls, the result queue fills, the back end stops, then the input
// queue fills and full rises; nothing is dropped.
// The registers are written through wr_en, wr_index and wr_data at any edge with wr_en
// high, and are meant to change only while no beat is in flight. Indexes past the last
// register are ignored.
// Asynchronous reset clears all tracking state, empties both queues and loads the
// register defaults: digital input, no inversion, debounce 50, click timeout 500,
// hold 700 and five clicks maximum.
`timescale 1ns / 1ps
`default_nettype none
module button_click_hold_detector import bchd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_index,
	input  wire logic [AGE_W-1:0] wr_data,
	input  wire logic             push,
	output logic                  full,
	input  wire item_t            item,
	output logic                  empty,
	input  wire logic             pop,
	output result_t               result
);

	cfg_t  cfg_q;
	tick_t tick;
	logic  take;

	// Register file. Only the low bits of the data that a register holds are kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_digital         <= 1'b1;
			cfg_q.invert_level        <= 1'b0;
			cfg_q.debounce_ticks      <= 16'd50;
			cfg_q.click_timeout_ticks <= 16'd500;
			cfg_q.hold_ticks          <= 16'd700;
			cfg_q.max_clicks          <= 8'd5;
		end else if (wr_en) begin
			case (wr_index)
				REG_USE_DIGITAL:   cfg_q.use_digital         <= wr_data[0];
				REG_INVERT_LEVEL:  cfg_q.invert_level        <= wr_data[0];
				REG_DEBOUNCE:      cfg_q.debounce_ticks      <= wr_data;
				REG_CLICK_TIMEOUT: cfg_q.click_timeout_ticks <= wr_data;
				REG_HOLD:          cfg_q.hold_ticks          <= wr_data;
				REG_MAX_CLICKS:    cfg_q.max_clicks          <= wr_data[CLICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The front end picks the raw level, inverts it when so configured, and queues it.
	bchd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.full   (full),
		.item   (item),
		.tick   (tick),
		.take   (take)
	);

	// The back end runs the debounce, click and hold logic and queues the results.
	bchd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.tick   (tick),
		.take   (take),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire
